// ===== rtl/tdp_pkg.sv =====
package tdp_pkg;

  localparam int MAX_SIDE = 64;
  localparam int POS_W = $clog2(MAX_SIDE);
  localparam int IDX_W = $clog2(MAX_SIDE + 1);
  localparam int SIZE_W = 7;
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);

  localparam logic [APB_AW-3:0] REG_MATRIX_SIZE = '0;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_FIX     = 2'd1,
    STATUS_CORRUPT = 2'd2
  } status_t;

  typedef struct packed {
    logic             data_bit;
    logic             last_col;
    logic             last_row;
    logic [POS_W-1:0] col_pos;
    logic [POS_W-1:0] row_pos;
  } item_t;

endpackage

// ===== rtl/tdp_front.sv =====
module tdp_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic [tdp_pkg::POS_W-1:0] side_m1,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic                      data_bit,
  output logic                      push,
  output tdp_pkg::item_t            push_item,
  input  logic                      queue_full
);

  logic [tdp_pkg::POS_W-1:0] col_pos;
  logic [tdp_pkg::POS_W-1:0] row_pos;
  logic [tdp_pkg::POS_W-1:0] col_pos_next;
  logic [tdp_pkg::POS_W-1:0] row_pos_next;
  logic                      last_col;
  logic                      last_row;

  assign in_ready = !queue_full;
  assign push     = in_valid && in_ready;
  assign last_col = (col_pos == side_m1);
  assign last_row = (row_pos == side_m1);

  // tag each bit with its position in the matrix
  always_comb begin
    push_item.data_bit = data_bit;
    push_item.last_col = last_col;
    push_item.last_row = last_row;
    push_item.col_pos  = col_pos;
    push_item.row_pos  = row_pos;
  end

  always_comb begin
    col_pos_next = col_pos;
    row_pos_next = row_pos;
    if (push) begin
      if (last_col) begin
        col_pos_next = '0;
        row_pos_next = last_row ? '0 : row_pos + 1'b1;
      end else begin
        col_pos_next = col_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col_pos <= '0;
      row_pos <= '0;
    end else begin
      col_pos <= col_pos_next;
      row_pos <= row_pos_next;
    end
  end

endmodule

// ===== rtl/tdp_queue.sv =====
module tdp_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           clear,
  input  logic           push,
  input  tdp_pkg::item_t push_item,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output tdp_pkg::item_t head_item
);

  tdp_pkg::item_t entries [tdp_pkg::QUEUE_DEPTH];
  logic [tdp_pkg::QPTR_W-1:0] wr_ptr;
  logic [tdp_pkg::QPTR_W-1:0] rd_ptr;
  logic [tdp_pkg::QCNT_W-1:0] count;

  assign full       = (count == tdp_pkg::QCNT_W'(tdp_pkg::QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_item  = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == tdp_pkg::QPTR_W'(tdp_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == tdp_pkg::QPTR_W'(tdp_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== rtl/tdp_back.sv =====
module tdp_back (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      clear,
  input  logic [tdp_pkg::POS_W-1:0] side_m1,
  input  logic                      head_valid,
  input  tdp_pkg::item_t            head_item,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [1:0]                status,
  output logic [tdp_pkg::IDX_W-1:0] bad_row,
  output logic [tdp_pkg::IDX_W-1:0] bad_col
);

  // column parities form a shift line whose length is the side in use
  logic [tdp_pkg::MAX_SIDE-1:0] col_par;
  logic [tdp_pkg::MAX_SIDE-1:0] col_par_next;
  logic                         row_par;
  logic [1:0]                   odd_row_cnt;
  logic [1:0]                   odd_col_cnt;
  logic [tdp_pkg::IDX_W-1:0]    odd_row_idx;
  logic [tdp_pkg::IDX_W-1:0]    odd_col_idx;

  logic [1:0]                   odd_row_cnt_next;
  logic [1:0]                   odd_col_cnt_next;
  logic [tdp_pkg::IDX_W-1:0]    odd_row_idx_next;
  logic [tdp_pkg::IDX_W-1:0]    odd_col_idx_next;
  logic                         cp;
  logic                         rp;
  logic                         tail;
  logic                         final_bit;
  tdp_pkg::status_t             status_next;

  assign final_bit = head_item.last_col && head_item.last_row;
  assign pop       = head_valid && (!final_bit || !out_valid || out_ready);
  assign cp        = col_par[0] ^ head_item.data_bit;
  assign rp        = row_par ^ head_item.data_bit;
  assign tail      = head_item.last_row ? 1'b0 : cp;

  always_comb begin
    odd_col_cnt_next = odd_col_cnt;
    odd_col_idx_next = odd_col_idx;
    if (head_item.last_row && cp) begin
      if (odd_col_cnt == 2'd0) begin
        odd_col_idx_next = tdp_pkg::IDX_W'(head_item.col_pos) + 1'b1;
      end
      if (odd_col_cnt != 2'd2) begin
        odd_col_cnt_next = odd_col_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    odd_row_cnt_next = odd_row_cnt;
    odd_row_idx_next = odd_row_idx;
    if (head_item.last_col && rp) begin
      if (odd_row_cnt == 2'd0) begin
        odd_row_idx_next = tdp_pkg::IDX_W'(head_item.row_pos) + 1'b1;
      end
      if (odd_row_cnt != 2'd2) begin
        odd_row_cnt_next = odd_row_cnt + 1'b1;
      end
    end
  end

  always_comb begin
    if (odd_row_cnt_next == 2'd0 && odd_col_cnt_next == 2'd0) begin
      status_next = tdp_pkg::STATUS_OK;
    end else if (odd_row_cnt_next == 2'd1 && odd_col_cnt_next == 2'd1) begin
      status_next = tdp_pkg::STATUS_FIX;
    end else begin
      status_next = tdp_pkg::STATUS_CORRUPT;
    end
  end

  always_comb begin
    for (int i = 0; i < tdp_pkg::MAX_SIDE; i++) begin
      if (tdp_pkg::POS_W'(i) == side_m1) begin
        col_par_next[i] = tail;
      end else if (tdp_pkg::POS_W'(i) < side_m1 && i < tdp_pkg::MAX_SIDE - 1) begin
        col_par_next[i] = col_par[(i + 1) % tdp_pkg::MAX_SIDE];
      end else begin
        col_par_next[i] = col_par[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst || clear) begin
      col_par     <= '0;
      row_par     <= 1'b0;
      odd_row_cnt <= '0;
      odd_col_cnt <= '0;
      odd_row_idx <= '0;
      odd_col_idx <= '0;
    end else if (pop) begin
      col_par <= col_par_next;
      row_par <= head_item.last_col ? 1'b0 : rp;
      if (final_bit) begin
        odd_row_cnt <= '0;
        odd_col_cnt <= '0;
        odd_row_idx <= '0;
        odd_col_idx <= '0;
      end else begin
        odd_row_cnt <= odd_row_cnt_next;
        odd_col_cnt <= odd_col_cnt_next;
        odd_row_idx <= odd_row_idx_next;
        odd_col_idx <= odd_col_idx_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      out_valid <= 1'b0;
    end else if (pop && final_bit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && final_bit) begin
      status <= status_next;
      if (status_next == tdp_pkg::STATUS_FIX) begin
        bad_row <= odd_row_idx_next;
        bad_col <= odd_col_idx_next;
      end else begin
        bad_row <= '0;
        bad_col <= '0;
      end
    end
  end

endmodule

// ===== rtl/two_d_parity_check.sv =====
// two-dimensional parity check with single-bit correction
//
// input channel: data_bit with in_valid/in_ready, one matrix bit per transfer
// in row-major order. output channel: status, bad_row, bad_col with
// out_valid/out_ready, one transfer per complete matrix. status ok means no
// odd row or column, fix gives the one-based row and column of the single
// flipped bit, corrupt covers every other pattern.
// apb port: register 0 at byte address 0 holds matrix_size (1..64, 0 is
// taken as 1, larger values as 64). a write drops any partial matrix.
// throughput: one bit per cycle while the queue has room; a two-entry queue decouples
// the position tracking front end from the parity engine.
// result path: the last bit of a matrix passes through the queue, and out_valid
// is registered when the parity engine pops that bit.
// a stalled receiver holds the result; the next matrix keeps streaming
// until its own last bit, which waits in the queue until the result leaves,
// and in_ready drops once the queue is full.
// reset: matrix_size returns to 8, all parities, counts and positions clear,
// no result is pending.
module two_d_parity_check (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [tdp_pkg::APB_AW-1:0] paddr,
  input  logic [tdp_pkg::APB_DW-1:0] pwdata,
  output logic [tdp_pkg::APB_DW-1:0] prdata,
  output logic                       pready,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic                       data_bit,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [1:0]                 status,
  output logic [tdp_pkg::IDX_W-1:0]  bad_row,
  output logic [tdp_pkg::IDX_W-1:0]  bad_col
);

  logic [tdp_pkg::SIZE_W-1:0] matrix_size;
  logic [tdp_pkg::POS_W-1:0]  side_m1;
  logic                       size_wr;
  logic                       push;
  logic                       pop;
  logic                       queue_full;
  logic                       head_valid;
  tdp_pkg::item_t             push_item;
  tdp_pkg::item_t             head_item;

  assign pready  = 1'b1;
  assign size_wr = psel && penable && pwrite && pready
                   && (paddr[tdp_pkg::APB_AW-1:2] == tdp_pkg::REG_MATRIX_SIZE);

  always_comb begin
    if (paddr[tdp_pkg::APB_AW-1:2] == tdp_pkg::REG_MATRIX_SIZE) begin
      prdata = tdp_pkg::APB_DW'(matrix_size);
    end else begin
      prdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix_size <= tdp_pkg::SIZE_RESET;
    end else if (size_wr) begin
      matrix_size <= pwdata[tdp_pkg::SIZE_W-1:0];
    end
  end

  always_comb begin
    if (matrix_size == '0) begin
      side_m1 = '0;
    end else if (int'(matrix_size) > tdp_pkg::MAX_SIDE) begin
      side_m1 = tdp_pkg::POS_W'(tdp_pkg::MAX_SIDE - 1);
    end else begin
      side_m1 = tdp_pkg::POS_W'(matrix_size - 1'b1);
    end
  end

  tdp_front u_front (
    .clk        (clk),
    .rst        (rst),
    .clear      (size_wr),
    .side_m1    (side_m1),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .data_bit   (data_bit),
    .push       (push),
    .push_item  (push_item),
    .queue_full (queue_full)
  );

  tdp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .clear      (size_wr),
    .push       (push),
    .push_item  (push_item),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_item  (head_item)
  );

  tdp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .clear      (size_wr),
    .side_m1    (side_m1),
    .head_valid (head_valid),
    .head_item  (head_item),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .status     (status),
    .bad_row    (bad_row),
    .bad_col    (bad_col)
  );

endmodule

// ===== verif/testbench.sv =====
module testbench;

  localparam int CLK_HALF = 6;
  localparam int RESET_CYCLES = 6;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 2000;
  localparam int RANDOM_ITEMS = 1390;
  localparam int CALM_AFTER = 1200;
  localparam int BIG_AFTER = 700;
  localparam int PLAN_LEN = 11;

  localparam logic [tdp_pkg::APB_AW-3:0] REG_SPARE = 1'b1;
  localparam logic [tdp_pkg::APB_AW-1:0] ADDR_SIZE = {tdp_pkg::REG_MATRIX_SIZE, 2'b00};
  localparam logic [tdp_pkg::APB_AW-1:0] ADDR_SPARE = {REG_SPARE, 2'b00};

  typedef enum int {MAT_CLEAN, MAT_ONE_FLIP, MAT_MULTI_FLIP, MAT_NOISE} mat_kind_t;

  typedef struct packed {
    tdp_pkg::status_t          st;
    logic [tdp_pkg::IDX_W-1:0] row;
    logic [tdp_pkg::IDX_W-1:0] col;
  } verdict_t;

  typedef struct packed {
    logic                       wr;
    logic [tdp_pkg::APB_AW-1:0] addr;
    logic [tdp_pkg::SIZE_W-1:0] data;
    logic [6:0]                 nbits;
    logic [63:0]                pattern;
    logic                       typed;
    verdict_t                   res;
  } step_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [tdp_pkg::APB_AW-1:0] paddr = '0;
  logic [tdp_pkg::APB_DW-1:0] pwdata = '0;
  logic [tdp_pkg::APB_DW-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_ready;
  logic data_bit = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [1:0] status;
  logic [tdp_pkg::IDX_W-1:0] bad_row;
  logic [tdp_pkg::IDX_W-1:0] bad_col;

  two_d_parity_check DUT (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .data_bit(data_bit),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status), .bad_row(bad_row), .bad_col(bad_col)
  );

  always begin
    #CLK_HALF clk = 1'b1;
    #CLK_HALF clk = 1'b0;
  end

  // predictor state
  logic [tdp_pkg::SIZE_W-1:0] size_reg = tdp_pkg::SIZE_RESET;
  bit                         row_par;
  bit                         col_par [tdp_pkg::MAX_SIDE];
  int unsigned                row_pos, col_pos;
  int unsigned                odd_rows, odd_cols;
  logic [tdp_pkg::IDX_W-1:0]  first_row, first_col;

  verdict_t verdict_q [$];
  verdict_t typed_verdict;
  bit       use_typed = 1'b0;
  verdict_t want;
  int       mismatches = 0;
  int       stall_cycles = 0;
  int       send_gap_pct = 0;
  int       recv_gap_pct = 0;
  int       hold_count = 0;
  int       hold_done = 0;
  bit       mat_q [$];
  step_t    plan [PLAN_LEN];

  function automatic void clear_matrix();
    row_par = 1'b0;
    foreach (col_par[i]) col_par[i] = 1'b0;
    row_pos = 0;
    col_pos = 0;
    odd_rows = 0;
    odd_cols = 0;
    first_row = '0;
    first_col = '0;
  endfunction

  function automatic int unsigned side_now();
    int unsigned s;
    s = 32'(size_reg);
    if (s == 0) s = 1;
    if (s > tdp_pkg::MAX_SIDE) s = tdp_pkg::MAX_SIDE;
    return s;
  endfunction

  function automatic bit check_matrix_bit(bit b, output verdict_t v);
    int unsigned s, c;
    bit lc, lr, cp, rp;
    s = side_now();
    c = col_pos;
    if (c >= s) c = s - 1;
    if (row_pos >= s) row_pos = s - 1;
    lc = (c == s - 1);
    lr = (row_pos == s - 1);
    cp = col_par[c] ^ b;
    if (lr) begin
      if (cp) begin
        if (odd_cols == 0) first_col = tdp_pkg::IDX_W'(c + 1);
        if (odd_cols < 2) odd_cols++;
      end
      col_par[c] = 1'b0;
    end else begin
      col_par[c] = cp;
    end
    rp = row_par ^ b;
    if (lc) begin
      if (rp) begin
        if (odd_rows == 0) first_row = tdp_pkg::IDX_W'(row_pos + 1);
        if (odd_rows < 2) odd_rows++;
      end
      row_par = 1'b0;
      col_pos = 0;
    end else begin
      row_par = rp;
      col_pos = c + 1;
    end
    if (!(lc && lr)) begin
      if (lc) row_pos++;
      return 1'b0;
    end
    if (odd_rows == 0 && odd_cols == 0) begin
      v = '{tdp_pkg::STATUS_OK, '0, '0};
    end else if (odd_rows == 1 && odd_cols == 1) begin
      v = '{tdp_pkg::STATUS_FIX, first_row, first_col};
    end else begin
      v = '{tdp_pkg::STATUS_CORRUPT, '0, '0};
    end
    clear_matrix();
    return 1'b1;
  endfunction

  task automatic send_bit(bit b);
    verdict_t v;
    if ($urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_valid <= 1'b1;
    data_bit <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (check_matrix_bit(b, v)) verdict_q.push_back(use_typed ? typed_verdict : v);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(logic [tdp_pkg::APB_AW-1:0] addr,
                           logic [tdp_pkg::APB_DW-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr[tdp_pkg::APB_AW-1:2] == tdp_pkg::REG_MATRIX_SIZE) begin
      size_reg = data[tdp_pkg::SIZE_W-1:0];
      clear_matrix();
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic build_matrix(int s, mat_kind_t kind);
    bit p;
    int idx;
    mat_q.delete();
    for (int i = 0; i < s * s; i++) mat_q.push_back(1'b0);
    for (int r = 0; r < s - 1; r++) begin
      p = 1'b0;
      for (int c = 0; c < s - 1; c++) begin
        mat_q[r * s + c] = 1'($urandom_range(0, 1));
        p ^= mat_q[r * s + c];
      end
      mat_q[r * s + s - 1] = p;
    end
    for (int c = 0; c < s; c++) begin
      p = 1'b0;
      for (int r = 0; r < s - 1; r++) p ^= mat_q[r * s + c];
      mat_q[(s - 1) * s + c] = p;
    end
    case (kind)
      MAT_ONE_FLIP: begin
        idx = $urandom_range(0, s * s - 1);
        mat_q[idx] = !mat_q[idx];
      end
      MAT_MULTI_FLIP: begin
        repeat ($urandom_range(2, 4)) begin
          idx = $urandom_range(0, s * s - 1);
          mat_q[idx] = !mat_q[idx];
        end
      end
      MAT_NOISE: begin
        foreach (mat_q[i]) mat_q[i] = 1'($urandom_range(0, 1));
      end
      default: begin
      end
    endcase
  endtask

  task automatic send_matrix();
    foreach (mat_q[i]) send_bit(mat_q[i]);
  endtask

  // receiver side
  initial begin
    forever begin
      @(posedge clk);
      if (hold_count != hold_done) begin
        hold_done = hold_count;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        out_ready <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_gap_pct) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (verdict_q.size() == 0) begin
        $error("result transfer with none pending: status %0d", status);
        mismatches++;
      end else begin
        want = verdict_q.pop_front();
        if (status !== want.st) begin
          $error("status expected %0d actual %0d", want.st, status);
          mismatches++;
        end
        if (bad_row !== want.row) begin
          $error("bad_row expected %0d actual %0d", want.row, bad_row);
          mismatches++;
        end
        if (bad_col !== want.col) begin
          $error("bad_col expected %0d actual %0d", want.col, bad_col);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable && pready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    int random_bits;
    int s, k, val, nmat, npart;
    bit big_done;
    mat_kind_t kind;

    random_bits = 0;
    big_done = 1'b0;
    clear_matrix();
    plan = '{
      // reset side of 8, clean matrix
      '{1'b0, ADDR_SIZE, 7'd0, 7'd64, 64'h0, 1'b1, '{tdp_pkg::STATUS_OK, 7'd0, 7'd0}},
      '{1'b1, ADDR_SIZE, 7'd1, 7'd1, 64'h0, 1'b1, '{tdp_pkg::STATUS_OK, 7'd0, 7'd0}},
      '{1'b0, ADDR_SIZE, 7'd0, 7'd1, 64'h1, 1'b1, '{tdp_pkg::STATUS_FIX, 7'd1, 7'd1}},
      // side of zero acts as one
      '{1'b1, ADDR_SIZE, 7'd0, 7'd1, 64'h1, 1'b1, '{tdp_pkg::STATUS_FIX, 7'd1, 7'd1}},
      '{1'b1, ADDR_SIZE, 7'd2, 7'd4, 64'h3, 1'b1, '{tdp_pkg::STATUS_CORRUPT, 7'd0, 7'd0}},
      // partial matrix dropped by the next write
      '{1'b1, ADDR_SIZE, 7'd3, 7'd5, 64'h16, 1'b0, '{tdp_pkg::STATUS_OK, 7'd0, 7'd0}},
      '{1'b1, ADDR_SIZE, 7'd3, 7'd9, 64'h100, 1'b1, '{tdp_pkg::STATUS_FIX, 7'd3, 7'd3}},
      // write to an unused register leaves the side alone
      '{1'b1, ADDR_SPARE, 7'd5, 7'd9, 64'h010, 1'b1, '{tdp_pkg::STATUS_FIX, 7'd2, 7'd2}},
      '{1'b0, ADDR_SIZE, 7'd0, 7'd9, 64'h1FF, 1'b1, '{tdp_pkg::STATUS_CORRUPT, 7'd0, 7'd0}},
      '{1'b1, ADDR_SIZE, 7'd4, 7'd16, 64'hA5C3, 1'b0, '{tdp_pkg::STATUS_OK, 7'd0, 7'd0}},
      '{1'b1, ADDR_SIZE, 7'd2, 7'd4, 64'h9, 1'b0, '{tdp_pkg::STATUS_OK, 7'd0, 7'd0}}
    };

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_gap_pct = 20;
    recv_gap_pct = 20;
    foreach (plan[i]) begin
      if (plan[i].wr) begin
        settle();
        cfg_write(plan[i].addr, tdp_pkg::APB_DW'(plan[i].data));
      end
      use_typed = plan[i].typed;
      typed_verdict = plan[i].res;
      for (int j = 0; j < plan[i].nbits; j++) send_bit(plan[i].pattern[j]);
      use_typed = 1'b0;
    end

    // long receiver hold while one-bit matrices keep coming
    settle();
    cfg_write(ADDR_SIZE, tdp_pkg::APB_DW'(1));
    send_gap_pct = 0;
    hold_count++;
    repeat (40) send_bit(1'($urandom_range(0, 1)));

    while (random_bits < RANDOM_ITEMS) begin
      if (random_bits >= CALM_AFTER) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end else begin
        k = $urandom_range(0, 2);
        send_gap_pct = (k == 0) ? 0 : (k == 1) ? 10 : 35;
        k = $urandom_range(0, 2);
        recv_gap_pct = (k == 0) ? 0 : (k == 1) ? 10 : 35;
      end

      // widest side: a few full rows, dropped by the next write
      if (!big_done && random_bits >= BIG_AFTER) begin
        big_done = 1'b1;
        settle();
        cfg_write(ADDR_SIZE, tdp_pkg::APB_DW'(tdp_pkg::MAX_SIDE));
        repeat (3 * tdp_pkg::MAX_SIDE) send_bit(1'($urandom_range(0, 1)));
        random_bits += 3 * tdp_pkg::MAX_SIDE;
        settle();
        cfg_write(ADDR_SIZE, tdp_pkg::APB_DW'(7'h7F));
        repeat (2 * tdp_pkg::MAX_SIDE) send_bit(1'($urandom_range(0, 1)));
        random_bits += 2 * tdp_pkg::MAX_SIDE;
      end

      k = $urandom_range(0, 19);
      if (k == 0) val = 0;
      else if (k <= 2) val = 1;
      else if (k <= 15) val = $urandom_range(2, 6);
      else if (k <= 18) val = $urandom_range(7, 16);
      else val = $urandom_range(17, 24);
      while (val > 1 && val * val > RANDOM_ITEMS - random_bits) val--;
      s = (val == 0) ? 1 : val;

      settle();
      if ($urandom_range(0, 4) == 0) cfg_write(ADDR_SPARE, $urandom());
      cfg_write(ADDR_SIZE, ($urandom() & 32'hFFFF_FF80) | tdp_pkg::APB_DW'(val));

      nmat = $urandom_range(1, 5);
      repeat (nmat) begin
        if (random_bits + s * s <= RANDOM_ITEMS) begin
          k = $urandom_range(0, 9);
          if (k <= 2) kind = MAT_CLEAN;
          else if (k <= 6) kind = MAT_ONE_FLIP;
          else if (k <= 8) kind = MAT_MULTI_FLIP;
          else kind = MAT_NOISE;
          build_matrix(s, kind);
          send_matrix();
          random_bits += s * s;
        end
      end

      // sometimes leave a partial matrix for the next write to drop
      if (s > 1 && random_bits + s * s <= RANDOM_ITEMS && $urandom_range(0, 3) == 0) begin
        npart = $urandom_range(1, s * s - 1);
        repeat (npart) send_bit(1'($urandom_range(0, 1)));
        random_bits += npart;
      end
    end

    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== two_d_parity_check.f =====
rtl/tdp_pkg.sv
rtl/tdp_front.sv
rtl/tdp_queue.sv
rtl/tdp_back.sv
rtl/two_d_parity_check.sv
verif/testbench.sv
